// ----- rtl/ppmp6_pkg.sv -----
// Package for the P6 stream parser: parse phases, result status codes,
// byte classes and sizing constants. No dependencies.
package ppmp6_pkg;

  // Width and height register size; dimension outputs carry the low 16 bits
  localparam int unsigned DimBits   = 16;
  localparam int unsigned OutDimW   = 16;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned WideBits  = DimBits + DigitBits;

  localparam logic [7:0] CharP    = 8'h50;  // 'P'
  localparam logic [7:0] Char6    = 8'h36;  // '6'
  localparam logic [7:0] CharZero = 8'h30;  // '0'
  localparam logic [7:0] CharNine = 8'h39;  // '9'
  localparam logic [7:0] CharSp   = 8'h20;  // space
  localparam logic [7:0] CharTab  = 8'h09;  // TAB, first of TAB..CR
  localparam logic [7:0] CharCr   = 8'h0D;  // CR, last of TAB..CR

  localparam logic [DimBits-1:0] MaxValue = DimBits'(255);

  typedef enum logic [3:0] {
    PH_MAGIC_P   = 4'd0,
    PH_MAGIC_6   = 4'd1,
    PH_SEP_FIRST = 4'd2,
    PH_GAP_W     = 4'd3,
    PH_NUM_W     = 4'd4,
    PH_GAP_H     = 4'd5,
    PH_NUM_H     = 4'd6,
    PH_GAP_M     = 4'd7,
    PH_NUM_M     = 4'd8,
    PH_RASTER    = 4'd9,
    PH_DONE      = 4'd10,
    PH_ERROR     = 4'd11,
    PH_TRUNC     = 4'd12
  } phase_e;

  typedef enum logic [2:0] {
    ST_HEADER = 3'd0,
    ST_PIXEL  = 3'd1,
    ST_LAST   = 3'd2,
    ST_ERROR  = 3'd3,
    ST_TRUNC  = 3'd4,
    ST_IGNORE = 3'd5
  } status_e;

  // Space, TAB, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CharSp) || ((b >= CharTab) && (b <= CharCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

endpackage

// ----- rtl/ppm_p6_stream_parser_top.sv -----
// P6 stream parser top level: header parse, raster counting, result register.
// Depends on ppmp6_pkg.
//
//   channel  direction  handshake                 fields
//   in       input      in_valid_i / in_stall_o   data_byte, start_of_file, end_of_stream
//   out      output     out_valid_o / out_stall_i status, pixel_value, image_width,
//                                                 image_height
//
// One item per cycle while the input is not stalled: each byte passes through the
// phase logic and lands in the result register on the edge that accepts it.
// The input stalls only while a held result is itself stalled.
// Reset (rst_ni low) returns the parser to the first magic byte with no result held.
// start_of_file restarts the parser on that same byte.
module ppm_p6_stream_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_file_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] pixel_value_o,
  output logic [ppmp6_pkg::OutDimW-1:0] image_width_o,
  output logic [ppmp6_pkg::OutDimW-1:0] image_height_o
);
  import ppmp6_pkg::*;

  phase_e               phase_q, phase_d, phase_eff, phase_n;
  logic [DimBits-1:0]   acc_q, acc_d, acc_eff;
  logic [DimBits-1:0]   width_q, width_d, width_eff;
  logic [DimBits-1:0]   height_q, height_d, height_eff;
  logic [1:0]           chan_q, chan_d, chan_eff;
  logic [DimBits-1:0]   col_q, col_d, col_eff;
  logic [DimBits-1:0]   row_q, row_d, row_eff;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [7:0]           pix_q, pix_d;
  logic [OutDimW-1:0]   img_w_q, img_w_d, img_h_q, img_h_d;

  logic                 in_accept;
  logic                 b_ws, b_digit;
  logic [WideBits-1:0]  acc_wide;
  logic                 dim_ovf, max_ovf;
  logic                 col_end, row_end;
  logic                 bad, trunc, last;

  // Handshake: accept while the result register is free or draining
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Start of file resets the state seen by this byte
  assign phase_eff  = start_of_file_i ? PH_MAGIC_P : phase_q;
  assign acc_eff    = start_of_file_i ? '0 : acc_q;
  assign width_eff  = start_of_file_i ? '0 : width_q;
  assign height_eff = start_of_file_i ? '0 : height_q;
  assign chan_eff   = start_of_file_i ? '0 : chan_q;
  assign col_eff    = start_of_file_i ? '0 : col_q;
  assign row_eff    = start_of_file_i ? '0 : row_q;

  // Byte classes and decimal accumulate (acc*10 + digit as two shifts)
  assign b_ws     = is_ws(data_byte_i);
  assign b_digit  = is_digit(data_byte_i);
  assign acc_wide = WideBits'({acc_eff, 3'b000}) + WideBits'({acc_eff, 1'b0})
                  + WideBits'(data_byte_i[DigitBits-1:0]);
  assign dim_ovf  = |acc_wide[WideBits-1:DimBits];
  assign max_ovf  = acc_wide > WideBits'(MaxValue);

  // Raster position wrap checks
  assign col_end = ({1'b0, col_eff} + 1'b1) >= {1'b0, width_eff};
  assign row_end = ({1'b0, row_eff} + 1'b1) >= {1'b0, height_eff};

  // Next state
  always_comb begin
    phase_n  = phase_eff;
    acc_d    = acc_eff;
    width_d  = width_eff;
    height_d = height_eff;
    chan_d   = chan_eff;
    col_d    = col_eff;
    row_d    = row_eff;
    bad      = 1'b0;
    last     = 1'b0;
    unique case (phase_eff)
      PH_MAGIC_P: begin
        if (data_byte_i == CharP) phase_n = PH_MAGIC_6;
        else bad = 1'b1;
      end
      PH_MAGIC_6: begin
        if (data_byte_i == Char6) phase_n = PH_SEP_FIRST;
        else bad = 1'b1;
      end
      PH_SEP_FIRST: begin
        if (b_ws) phase_n = PH_GAP_W;
        else bad = 1'b1;
      end
      PH_GAP_W, PH_GAP_H, PH_GAP_M: begin
        if (!b_ws) begin
          if (!b_digit) begin
            bad = 1'b1;
          end else begin
            // a single digit never exceeds either limit
            acc_d = DimBits'(data_byte_i[DigitBits-1:0]);
            case (phase_eff)
              PH_GAP_W: phase_n = PH_NUM_W;
              PH_GAP_H: phase_n = PH_NUM_H;
              default:  phase_n = PH_NUM_M;
            endcase
          end
        end
      end
      PH_NUM_W, PH_NUM_H: begin
        if (b_digit) begin
          if (dim_ovf) bad = 1'b1;
          else acc_d = acc_wide[DimBits-1:0];
        end else if (b_ws && (acc_eff != '0)) begin
          if (phase_eff == PH_NUM_W) begin
            width_d = acc_eff;
            phase_n = PH_GAP_H;
          end else begin
            height_d = acc_eff;
            phase_n  = PH_GAP_M;
          end
          acc_d = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_NUM_M: begin
        if (b_digit) begin
          if (max_ovf) bad = 1'b1;
          else acc_d = acc_wide[DimBits-1:0];
        end else if (b_ws && (acc_eff == MaxValue)) begin
          acc_d   = '0;
          chan_d  = '0;
          col_d   = '0;
          row_d   = '0;
          phase_n = PH_RASTER;
        end else begin
          bad = 1'b1;
        end
      end
      PH_RASTER: begin
        if (chan_eff >= 2'd2) begin
          chan_d = '0;
          if (col_end) begin
            col_d = '0;
            if (row_end) begin
              phase_n = PH_DONE;
              last    = 1'b1;
            end else begin
              row_d = row_eff + 1'b1;
            end
          end else begin
            col_d = col_eff + 1'b1;
          end
        end else begin
          chan_d = chan_eff + 1'b1;
        end
      end
      PH_DONE, PH_TRUNC: ;
      default: bad = 1'b1;  // sticky error
    endcase

    // Errors win over early end of stream
    trunc = !bad && end_of_stream_i && (phase_n != PH_DONE);
    if (bad)        phase_d = PH_ERROR;
    else if (trunc) phase_d = PH_TRUNC;
    else            phase_d = phase_n;
  end

  // Result fields
  always_comb begin
    if (bad) begin
      status_d = ST_ERROR;
    end else if (trunc) begin
      status_d = ST_TRUNC;
    end else begin
      unique case (phase_eff)
        PH_RASTER: status_d = last ? ST_LAST : ST_PIXEL;
        PH_DONE:   status_d = ST_IGNORE;
        PH_TRUNC:  status_d = ST_TRUNC;
        default:   status_d = ST_HEADER;
      endcase
    end
    pix_d = ((status_d == ST_PIXEL) || (status_d == ST_LAST)) ? data_byte_i : 8'd0;
    if ((phase_d == PH_RASTER) || (phase_d == PH_DONE)) begin
      img_w_d = OutDimW'(width_d);
      img_h_d = OutDimW'(height_d);
    end else begin
      img_w_d = '0;
      img_h_d = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC_P;
      acc_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      chan_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (in_accept) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      width_q  <= width_d;
      height_q <= height_d;
      chan_q   <= chan_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      pix_q    <= pix_d;
      img_w_q  <= img_w_d;
      img_h_q  <= img_h_d;
    end
  end

  assign status_o       = status_q;
  assign pixel_value_o  = pix_q;
  assign image_width_o  = img_w_q;
  assign image_height_o = img_h_q;

  // Checks
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR) && !(in_accept && start_of_file_i) |=> (phase_q == PH_ERROR))
    else $error("error phase left without start of file");

  a_last_has_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_LAST) |-> (image_width_o != '0) && (image_height_o != '0))
    else $error("last raster item without dimensions");

  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_PIXEL) && (status_o != ST_LAST) |-> (pixel_value_o == 8'd0))
    else $error("pixel value on a non-raster item");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q != 2'd3)
    else $error("channel counter out of range");

endmodule

// ----- dv/tb_ppm_p6_stream_parser_top.sv -----
// Self-checking testbench for the P6 stream parser: directed rows, then random files.
// Depends on ppmp6_pkg and ppm_p6_stream_parser_top.
module tb_ppm_p6_stream_parser_top;
  import ppmp6_pkg::*;

  localparam int unsigned AccW     = WideBits + 1;
  localparam logic [AccW-1:0] DimMax = AccW'((64'd1 << DimBits) - 1);
  localparam logic [AccW-1:0] MaxLvl = AccW'(255);
  localparam int unsigned LongHold = 300;
  localparam int unsigned NumRows  = 21;

  typedef struct packed {
    status_e             status;
    logic [7:0]          pixel;
    logic [OutDimW-1:0]  dim_w;
    logic [OutDimW-1:0]  dim_h;
  } result_t;

  typedef struct {
    logic [7:0] b;
    logic       sof;
    logic       eos;
    logic       known;
    result_t    r;
  } dir_row_t;

  localparam result_t R_NONE  = '{ST_HEADER, 8'h00, 16'd0, 16'd0};
  localparam result_t R_ERR   = '{ST_ERROR, 8'h00, 16'd0, 16'd0};
  localparam result_t R_TRUNC = '{ST_TRUNC, 8'h00, 16'd0, 16'd0};
  localparam result_t R_LAST  = '{ST_LAST, 8'hFF, 16'd1, 16'd1};
  localparam result_t R_IGN   = '{ST_IGNORE, 8'h00, 16'd1, 16'd1};

  // Clock, reset, block ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte = 8'h00;
  logic                in_sof = 1'b0;
  logic                in_eos = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          out_status;
  logic [7:0]          out_pixel;
  logic [OutDimW-1:0]  out_w;
  logic [OutDimW-1:0]  out_h;

  // Predictor state
  phase_e              prs_phase;
  logic [16:0]         num_acc;
  logic [DimBits-1:0]  img_w;
  logic [DimBits-1:0]  img_h;
  logic [1:0]          chan_cnt;
  logic [DimBits-1:0]  col_cnt;
  logic [DimBits-1:0]  row_cnt;

  result_t             result_q[$];
  logic [7:0]          file_q[$];
  dir_row_t            dir_rows[NumRows];
  int unsigned         n_items = 0;
  int unsigned         n_mismatch = 0;
  int unsigned         idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         hold_arm = 0;
  int unsigned         hold_seen = 0;
  int unsigned         hold_left = 0;

  ppm_p6_stream_parser_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (in_byte),
    .start_of_file_i (in_sof),
    .end_of_stream_i (in_eos),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (out_status),
    .pixel_value_o   (out_pixel),
    .image_width_o   (out_w),
    .image_height_o  (out_h)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte classes
  function automatic logic ws_byte(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic digit_byte(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic void clear_parser();
    prs_phase = PH_MAGIC_P;
    num_acc   = '0;
    img_w     = '0;
    img_h     = '0;
    chan_cnt  = '0;
    col_cnt   = '0;
    row_cnt   = '0;
  endfunction

  // Header parse and raster count for one byte; returns the expected result
  function automatic result_t parse_byte(logic [7:0] b, logic sof, logic eos);
    result_t         r;
    logic            bad;
    logic [AccW-1:0] nxt;
    logic [AccW-1:0] lim;
    r   = R_NONE;
    bad = 1'b0;
    if (sof) clear_parser();
    nxt = AccW'(num_acc) * AccW'(10) + AccW'(b - 8'h30);
    case (prs_phase)
      PH_MAGIC_P: begin
        if (b == 8'h50) prs_phase = PH_MAGIC_6;
        else bad = 1'b1;
      end
      PH_MAGIC_6: begin
        if (b == 8'h36) prs_phase = PH_SEP_FIRST;
        else bad = 1'b1;
      end
      PH_SEP_FIRST: begin
        if (ws_byte(b)) prs_phase = PH_GAP_W;
        else bad = 1'b1;
      end
      PH_GAP_W, PH_GAP_H, PH_GAP_M: begin
        if (!ws_byte(b)) begin
          if (!digit_byte(b)) begin
            bad = 1'b1;
          end else begin
            lim = (prs_phase == PH_GAP_M) ? MaxLvl : DimMax;
            nxt = AccW'(b - 8'h30);
            if (nxt > lim) begin
              bad = 1'b1;
            end else begin
              num_acc   = 17'(nxt);
              prs_phase = phase_e'(prs_phase + 4'd1);
            end
          end
        end
      end
      PH_NUM_W, PH_NUM_H: begin
        if (digit_byte(b)) begin
          if (nxt > DimMax) bad = 1'b1;
          else num_acc = 17'(nxt);
        end else if (ws_byte(b) && num_acc != '0) begin
          if (prs_phase == PH_NUM_W) begin
            img_w     = DimBits'(num_acc);
            prs_phase = PH_GAP_H;
          end else begin
            img_h     = DimBits'(num_acc);
            prs_phase = PH_GAP_M;
          end
          num_acc = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_NUM_M: begin
        if (digit_byte(b)) begin
          if (nxt > MaxLvl) bad = 1'b1;
          else num_acc = 17'(nxt);
        end else if (ws_byte(b) && AccW'(num_acc) == MaxLvl) begin
          num_acc   = '0;
          chan_cnt  = '0;
          col_cnt   = '0;
          row_cnt   = '0;
          prs_phase = PH_RASTER;
        end else begin
          bad = 1'b1;
        end
      end
      PH_RASTER: begin
        r.pixel  = b;
        r.status = ST_PIXEL;
        if (chan_cnt >= 2'd2) begin
          chan_cnt = '0;
          if ({1'b0, col_cnt} + 1'b1 >= {1'b0, img_w}) begin
            col_cnt = '0;
            if ({1'b0, row_cnt} + 1'b1 >= {1'b0, img_h}) begin
              prs_phase = PH_DONE;
              r.status  = ST_LAST;
            end else begin
              row_cnt = row_cnt + 1'b1;
            end
          end else begin
            col_cnt = col_cnt + 1'b1;
          end
        end else begin
          chan_cnt = chan_cnt + 1'b1;
        end
      end
      PH_DONE:  r.status = ST_IGNORE;
      PH_TRUNC: r.status = ST_TRUNC;
      default:  bad = 1'b1;
    endcase
    // Format error wins over early end
    if (bad) begin
      prs_phase = PH_ERROR;
      r.status  = ST_ERROR;
      r.pixel   = '0;
    end else if (eos && prs_phase != PH_DONE) begin
      prs_phase = PH_TRUNC;
      r.status  = ST_TRUNC;
      r.pixel   = '0;
    end
    if (prs_phase == PH_RASTER || prs_phase == PH_DONE) begin
      r.dim_w = OutDimW'(img_w);
      r.dim_h = OutDimW'(img_h);
    end
    return r;
  endfunction

  // File builders
  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic void add_ws();
    repeat ($urandom_range(1, 3)) file_q.push_back(ws_char());
  endfunction

  // Decimal text, sometimes with leading zeros
  function automatic void add_num(string s);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) file_q.push_back(8'h30);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  function automatic void make_header(string ws_txt, string hs_txt, string mx_txt,
                                      logic sep);
    file_q.push_back(8'h50);
    file_q.push_back(8'h36);
    if (sep) add_ws();
    add_num(ws_txt);
    add_ws();
    add_num(hs_txt);
    add_ws();
    add_num(mx_txt);
    file_q.push_back(ws_char());
  endfunction

  // Offer one item, wait for acceptance, record its expectation, then maybe idle
  task automatic put_byte(logic [7:0] b, logic s, logic e, logic known, result_t r);
    result_t p;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_sof   <= s;
    in_eos   <= e;
    do @(posedge clk); while (!in_valid || in_stall);
    p = parse_byte(b, s, e);
    result_q.push_back(known ? r : p);
    n_items++;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_file(logic sof_first, logic eos_last);
    for (int i = 0; i < file_q.size(); i++)
      put_byte(file_q[i], sof_first && i == 0, eos_last && i == file_q.size() - 1,
               1'b0, R_NONE);
  endtask

  // Receiver: stall pattern, long hold-off, result check
  always @(posedge clk) begin : rx
    result_t exp_r;
    if (out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: status %0d pixel %0h w %0d h %0d",
                   out_status, out_pixel, out_w, out_h);
      end else begin
        exp_r = result_q.pop_front();
        if (out_status != exp_r.status || out_pixel != exp_r.pixel ||
            out_w != exp_r.dim_w || out_h != exp_r.dim_h) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at %0t: status %0d/%0d pixel %0h/%0h w %0d/%0d h %0d/%0d",
                     $time, exp_r.status, out_status, exp_r.pixel, out_pixel,
                     exp_r.dim_w, out_w, exp_r.dim_h, out_h);
        end
      end
    end
    if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : main
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned n_pix;
    int unsigned phase_ix;
    int unsigned guard;
    logic        big;
    logic        sep;
    logic        eos_last;
    string       ws_txt;
    string       hs_txt;
    string       mx_txt;

    clear_parser();
    // Magic error after reset, sticky error, a 1x1 file whose raster starts with
    // whitespace, ignored tail, early end, and a bad magic with restart
    dir_rows = '{
      '{8'h58, 1'b0, 1'b0, 1'b1, R_ERR},
      '{8'h36, 1'b0, 1'b1, 1'b1, R_ERR},
      '{8'h50, 1'b1, 1'b0, 1'b1, R_NONE},
      '{8'h36, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h20, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h31, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h09, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h31, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h0A, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h32, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h35, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h35, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h0D, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h0A, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'h00, 1'b0, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, 1'b1, R_LAST},
      '{8'h00, 1'b0, 1'b0, 1'b1, R_IGN},
      '{8'hFF, 1'b0, 1'b1, 1'b1, R_IGN},
      '{8'h50, 1'b1, 1'b1, 1'b1, R_TRUNC},
      '{8'hFF, 1'b0, 1'b0, 1'b1, R_TRUNC},
      '{8'h5A, 1'b1, 1'b0, 1'b1, R_ERR}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++)
      put_byte(dir_rows[i].b, dir_rows[i].sof, dir_rows[i].eos, dir_rows[i].known,
               dir_rows[i].r);

    // Long receiver hold-off while the sender keeps offering items
    hold_arm <= hold_arm + 1;

    while (n_items < NumRows + 600) begin
      phase_ix = ((n_items - NumRows) / 150) % 4;
      case (phase_ix)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 50; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 50; end
        default: begin idle_pct = 16; stall_pct <= 16; end
      endcase

      kind = $urandom_range(0, 9);
      file_q.delete();
      w    = $urandom_range(1, 4);
      h    = $urandom_range(1, 3);
      big  = ($urandom_range(0, 15) == 0);
      if (big) begin
        if ($urandom_range(0, 1)) w = 65535;
        else h = 65535;
      end
      ws_txt   = $sformatf("%0d", w);
      hs_txt   = $sformatf("%0d", h);
      mx_txt   = "255";
      sep      = 1'b1;
      eos_last = 1'($urandom_range(0, 1));

      if (kind == 9) begin
        // Noise with random restart and end flags
        repeat ($urandom_range(1, 12))
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                   $urandom_range(0, 7) == 0, 1'b0, R_NONE);
      end else begin
        if (kind == 8) begin
          big = 1'b0;
          case ($urandom_range(0, 8))
            0:       ws_txt = "0";
            1:       hs_txt = "000";
            2:       ws_txt = "65536";
            3:       hs_txt = "99999";
            4:       mx_txt = "256";
            5:       mx_txt = "254";
            6:       mx_txt = "2550";
            7:       sep = 1'b0;
            default: ws_txt = $sformatf("%0dx", w);
          endcase
        end
        make_header(ws_txt, hs_txt, mx_txt, sep);
        // Corrupt one header byte
        if (kind == 7) file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
        n_pix = big ? $urandom_range(1, 12) : 3 * w * h;
        repeat (n_pix) begin
          if ($urandom_range(0, 7) == 0) file_q.push_back(ws_char());
          else file_q.push_back(8'($urandom_range(0, 255)));
        end
        if (big) eos_last = 1'b1;
        else repeat ($urandom_range(0, 2)) file_q.push_back(8'($urandom_range(0, 255)));
        // Cut short; every file is sent with start of file on its first byte, so the next one restarts
        if (kind == 6) begin
          while (file_q.size() > 1 && $urandom_range(0, 3) != 0) void'(file_q.pop_back());
        end
        send_file(1'b1, eos_last);
      end
    end
    in_valid  <= 1'b0;
    stall_pct <= 0;

    guard = 0;
    while (result_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    n_mismatch += result_q.size();

    if (n_mismatch == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
